@@ rtl/core/bsm_pkg.sv @@
// Shared types and constants for the bank switching mapper core.
package bsm_pkg;

   // Work RAM size in bytes
   localparam int unsigned RAM_BYTES_DEF = 8192;

   // Item modes
   localparam logic [2:0] MODE_CPU_RD = 3'd0;
   localparam logic [2:0] MODE_CPU_WR = 3'd1;
   localparam logic [2:0] MODE_PPU_RD = 3'd2;
   localparam logic [2:0] MODE_PPU_WR = 3'd3;
   localparam logic [2:0] MODE_TICK   = 3'd4;

   // Result targets
   localparam logic [1:0] TGT_NONE = 2'd0;
   localparam logic [1:0] TGT_RAM  = 2'd1;
   localparam logic [1:0] TGT_PRG  = 2'd2;
   localparam logic [1:0] TGT_CHR  = 2'd3;

   // Mapper commands that are decoded individually
   localparam logic [3:0] CMD_PRG0     = 4'd8;
   localparam logic [3:0] CMD_MIRROR   = 4'd12;
   localparam logic [3:0] CMD_IRQ_CTRL = 4'd13;
   localparam logic [3:0] CMD_CNT_LO   = 4'd14;

   // Mirroring after reset: horizontal
   localparam logic [1:0] MIRROR_RESET = 2'd1;

   // Configuration register indexes (byte address bit 2)
   localparam logic REG_PRG_SIZE = 1'b0;
   localparam logic REG_CHR_SIZE = 1'b1;

   // Configuration register reset value
   localparam logic [5:0] SIZE_RESET = 6'd32;

   // One input item
   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] bus_address;
      logic [7:0]  write_value;
      logic [7:0]  tick_cycles;
   } req_type;

   // One result item
   typedef struct packed {
      logic        handled;
      logic [1:0]  target;
      logic [18:0] rom_address;
      logic [7:0]  read_data;
      logic        read_valid;
      logic        irq_pulse;
      logic [1:0]  mirror_mode;
   } rsp_type;

endpackage

@@ rtl/core/bsm_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module bsm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read data only changes on an enabled read, so it holds while the consumer waits
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bank_switching_mapper_irq_core.sv @@
// Bank switching cartridge mapper with cycle-count IRQ timer. The block takes one
// transfer per clock while req_stall is low (bus read, bus write or tick) and returns
// one result per item: the access is decoded and all mapper registers are
// updated in the accept cycle, the work RAM (single port, one access per cycle)
// returns its byte in the next cycle, and an output register follows. Sustained rate
// is one item per clock while rsp_stall is low. After reset the work RAM is cleared
// one byte per clock over all RAM_BYTES bytes (8192 by default), during which req_stall
// is high; configuration writes are taken throughout.
module bank_switching_mapper_irq_core #(
   parameter int unsigned RAM_BYTES = bsm_pkg::RAM_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // item channel
   input  logic             req_valid,
   output logic             req_stall,
   input  bsm_pkg::req_type req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bsm_pkg::rsp_type rsp_data,
   // register port
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   import bsm_pkg::*;

   localparam int unsigned AW = $clog2(RAM_BYTES);

   // Configuration registers
   logic [5:0] prg_size_ff, prg_size_in;
   logic [5:0] chr_size_ff, chr_size_in;

   // Mapper state
   logic [3:0]  cmd_ff, cmd_in;
   logic [7:0]  chr_bank_ff [8];
   logic [7:0]  chr_bank_in [8];
   logic [5:0]  prg_bank_ff [4];
   logic [5:0]  prg_bank_in [4];
   logic        ram_sel_ff, ram_sel_in;
   logic        ram_en_ff, ram_en_in;
   logic        irq_en_ff, irq_en_in;
   logic        cnt_en_ff, cnt_en_in;
   logic [15:0] irq_count_ff, irq_count_in;
   logic [1:0]  mirror_ff, mirror_in;

   // RAM clearing pass
   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // Pipeline
   logic    s1_valid_ff, s1_valid_in;
   rsp_type s1_data_ff, s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic          req_acc;
   logic          s1_adv;
   logic          csr_wr;
   logic [5:0]    prg_bank_mask;
   logic [7:0]    chr_bank_mask;
   logic [5:0]    prg_bank_sel;
   logic [16:0]   count_diff;
   logic          ram_en;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rd_data;

   // Handshakes
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_adv);
   assign req_acc   = req_valid && !req_stall;
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CHR_SIZE) ? {26'd0, chr_size_ff}
                                                      : {26'd0, prg_size_ff};

   always_comb begin
      prg_size_in = prg_size_ff;
      chr_size_in = chr_size_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_PRG_SIZE) begin
            prg_size_in = csr_pwdata[5:0];
         end else begin
            chr_size_in = csr_pwdata[5:0];
         end
      end
   end

   // Size masks wrap within the bank width
   assign prg_bank_mask = {prg_size_ff[4:0], 1'b0} - 6'd1;
   assign chr_bank_mask = {chr_size_ff[4:0], 3'b000} - 8'd1;

   // Three switchable 8K windows at 8000-DFFF, fixed last bank at E000-FFFF
   always_comb begin
      unique case (req_data.bus_address[14:13])
         2'd0:    prg_bank_sel = prg_bank_ff[1];
         2'd1:    prg_bank_sel = prg_bank_ff[2];
         2'd2:    prg_bank_sel = prg_bank_ff[3];
         default: prg_bank_sel = prg_bank_mask;
      endcase
   end

   assign count_diff = {1'b0, irq_count_ff} - {9'd0, req_data.tick_cycles};

   // Item decode and register update
   always_comb begin
      cmd_in       = cmd_ff;
      chr_bank_in  = chr_bank_ff;
      prg_bank_in  = prg_bank_ff;
      ram_sel_in   = ram_sel_ff;
      ram_en_in    = ram_en_ff;
      irq_en_in    = irq_en_ff;
      cnt_en_in    = cnt_en_ff;
      irq_count_in = irq_count_ff;
      mirror_in    = mirror_ff;
      s1_data_in   = '0;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = req_data.bus_address[AW-1:0];
      ram_wdata    = req_data.write_value;

      if (req_acc) begin
         unique case (req_data.mode)
            MODE_CPU_RD: begin
               if (req_data.bus_address[15]) begin
                  s1_data_in.handled     = 1'b1;
                  s1_data_in.target      = TGT_PRG;
                  s1_data_in.rom_address = {prg_bank_sel, req_data.bus_address[12:0]};
               end else if (req_data.bus_address[14:13] == 2'b11) begin
                  s1_data_in.handled = 1'b1;
                  if (ram_sel_ff) begin
                     s1_data_in.target = TGT_RAM;
                     if (ram_en_ff) begin
                        s1_data_in.read_valid = 1'b1;
                        ram_en                = 1'b1;
                     end
                  end else begin
                     s1_data_in.target      = TGT_PRG;
                     s1_data_in.rom_address = {prg_bank_ff[0], req_data.bus_address[12:0]};
                  end
               end
            end
            MODE_CPU_WR: begin
               if (req_data.bus_address[15:13] == 3'b011) begin
                  s1_data_in.handled = 1'b1;
                  if (ram_sel_ff) begin
                     s1_data_in.target = TGT_RAM;
                     if (ram_en_ff) begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                     end
                  end
               end else if (req_data.bus_address[15:13] == 3'b100) begin
                  cmd_in = req_data.write_value[3:0];
               end else if (req_data.bus_address[15:13] == 3'b101) begin
                  // parameter for the latched command
                  if (!cmd_ff[3]) begin
                     chr_bank_in[cmd_ff[2:0]] = req_data.write_value & chr_bank_mask;
                  end else if (!cmd_ff[2]) begin
                     prg_bank_in[cmd_ff[1:0]] = req_data.write_value[5:0] & prg_bank_mask;
                     if (cmd_ff == CMD_PRG0) begin
                        ram_sel_in = req_data.write_value[6];
                        ram_en_in  = req_data.write_value[7];
                     end
                  end else if (cmd_ff == CMD_MIRROR) begin
                     mirror_in = req_data.write_value[1:0];
                  end else if (cmd_ff == CMD_IRQ_CTRL) begin
                     irq_en_in = req_data.write_value[0];
                     cnt_en_in = req_data.write_value[7];
                  end else if (cmd_ff == CMD_CNT_LO) begin
                     irq_count_in = {irq_count_ff[15:8], req_data.write_value};
                  end else begin
                     irq_count_in = {req_data.write_value, irq_count_ff[7:0]};
                  end
               end
            end
            MODE_PPU_RD: begin
               if (req_data.bus_address[15:13] == 3'b000) begin
                  s1_data_in.handled     = 1'b1;
                  s1_data_in.target      = TGT_CHR;
                  s1_data_in.rom_address = {1'b0, chr_bank_ff[req_data.bus_address[12:10]],
                                            req_data.bus_address[9:0]};
               end
            end
            MODE_TICK: begin
               if (cnt_en_ff) begin
                  irq_count_in         = count_diff[15:0];
                  s1_data_in.irq_pulse = count_diff[16] && irq_en_ff;
               end
            end
            default: begin
               // PPU writes and unused modes leave the state alone
            end
         endcase
      end

      // clearing pass owns the RAM port
      if (clearing_ff) begin
         ram_en    = 1'b1;
         ram_we    = 1'b1;
         ram_addr  = clr_addr_ff;
         ram_wdata = '0;
      end

      s1_data_in.mirror_mode = mirror_in;
   end

   // Clear sequencer
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(RAM_BYTES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // Pipeline control and output stage
   always_comb begin
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         rsp_data_in           = s1_data_ff;
         rsp_data_in.read_data = s1_data_ff.read_valid ? ram_rd_data : 8'd0;
      end
   end

   // Work RAM
   bsm_ram #(
      .WIDTH (8),
      .DEPTH (RAM_BYTES)
   ) u_work_ram (
      .clock   (clock),
      .en      (ram_en),
      .we      (ram_we),
      .addr    (ram_addr),
      .wdata   (ram_wdata),
      .rd_data (ram_rd_data)
   );

   // Control and mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_size_ff  <= SIZE_RESET;
         chr_size_ff  <= SIZE_RESET;
         cmd_ff       <= '0;
         chr_bank_ff  <= '{default: '0};
         prg_bank_ff  <= '{default: '0};
         ram_sel_ff   <= 1'b0;
         ram_en_ff    <= 1'b0;
         irq_en_ff    <= 1'b0;
         cnt_en_ff    <= 1'b0;
         irq_count_ff <= '0;
         mirror_ff    <= MIRROR_RESET;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prg_size_ff  <= prg_size_in;
         chr_size_ff  <= chr_size_in;
         cmd_ff       <= cmd_in;
         chr_bank_ff  <= chr_bank_in;
         prg_bank_ff  <= prg_bank_in;
         ram_sel_ff   <= ram_sel_in;
         ram_en_ff    <= ram_en_in;
         irq_en_ff    <= irq_en_in;
         cnt_en_ff    <= cnt_en_in;
         irq_count_ff <= irq_count_in;
         mirror_ff    <= mirror_in;
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_data_ff <= s1_data_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // no item enters while the RAM is being cleared
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_acc)
      else $error("item accepted during RAM clear");

   // RAM read data must hold while its item waits in the first stage
   a_rd_data_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> $stable(ram_rd_data))
      else $error("RAM read data lost while stalled");

   // counter stays put on a tick while counting is disabled
   a_count_frozen: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_data.mode == MODE_TICK && !cnt_en_ff) |=> $stable(irq_count_ff))
      else $error("counter moved while disabled");

   // RAM data only ever comes with a RAM target
   a_rvalid_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.read_valid) |-> (rsp_data.target == TGT_RAM))
      else $error("read data without RAM target");
`endif

endmodule
